FILE: src/riu_pkg.sv
// Shared constants and types for the raster integer upscaler.
`timescale 1ns / 1ps

package riu_pkg;

    localparam int SCALE_W  = 7;
    localparam int SWIDTH_W = 11;
    localparam int HEIGHT_W = 13;
    localparam int ROWCNT_W = 12;
    localparam int CFG_W    = 13;

    localparam logic [SCALE_W-1:0]  SCALE_MAX  = 7'd100;
    localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = 13'd4096;
    localparam logic [7:0]          PAD_BYTE   = 8'h00;

    typedef logic [1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_SCALE  = 2'd0;
    localparam t_cfg_idx CFG_WIDTH  = 2'd1;
    localparam t_cfg_idx CFG_HEIGHT = 2'd2;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_TICK = 1'b1;

endpackage

FILE: src/raster_integer_upscaler_unit.sv
// Pixel-replicating integer upscaler for a padded 24-bit raster, line store in block memory.
// A tick's byte is read into the read stage, then the output register. Throughput:
// one input transfer per cycle unless the output stalls; the line store has one write and one read
// port and writes and reads never fall in the same cycle, since a row is filled or drained.
// Reset (synchronous, active low) clears counters, the row flag and the pipeline valids and
// sets all three registers to 1; line store contents stay undefined until written.
`timescale 1ns / 1ps

module raster_integer_upscaler_unit
    import riu_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // source side
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  logic [7:0]          i_s_axis_tdata,   // [7:0] data_byte
    input  logic                i_s_axis_tuser,   // [0] kind
    // result side
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    output logic [7:0]          o_m_axis_tdata,   // [7:0] out_byte
    output logic                o_m_axis_tlast,   // row_end
    output logic                o_m_axis_tuser,   // [0] image_end
    // register writes
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  t_cfg_idx            i_cfg_index,
    input  logic [CFG_W-1:0]    i_cfg_data
);

    localparam int EFF_MAX = (MAX_WIDTH < 2047) ? MAX_WIDTH : 2047;
    localparam int WW      = $clog2(EFF_MAX + 1);
    localparam int ROW_W   = $clog2(3 * EFF_MAX + 4);
    localparam int DEPTH   = 3 * MAX_WIDTH;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // configuration
    logic [SCALE_W-1:0]  r_scale;
    logic [SWIDTH_W-1:0] r_src_width;
    logic [HEIGHT_W-1:0] r_src_height;

    // control state
    logic [ROW_W-1:0]    r_in_pos,   n_in_pos;
    logic                r_row_ready, n_row_ready;
    logic [WW-1:0]       r_pix_pos,  n_pix_pos;
    logic [1:0]          r_bip,      n_bip;
    logic [SCALE_W-1:0]  r_rep,      n_rep;
    logic [SCALE_W-1:0]  r_copy,     n_copy;
    logic [1:0]          r_pad,      n_pad;
    logic [ROWCNT_W-1:0] r_src_row,  n_src_row;

    // pipeline
    logic                r_b_vld, r_b_pad, r_b_last, r_b_img;
    logic [7:0]          r_q;
    logic                r_o_vld, r_o_last, r_o_img;
    logic [7:0]          r_o_data;

    logic [7:0]          r_line_store [DEPTH];

    logic [SCALE_W-1:0]  eff_s;
    logic [WW-1:0]       eff_w;
    logic [HEIGHT_W-1:0] eff_h;
    logic [ROW_W-1:0]    data_len, row_len;
    logic [1:0]          pad_out;
    logic                s_ready, accept, byte_go, tick_go, b_move;
    logic                wr_en, rd_en, in_data;
    logic [AW-1:0]       wr_addr, rd_addr;
    logic                row_end, img_end;

    always_comb begin
        if (r_scale == '0) begin
            eff_s = SCALE_W'(1);
        end else if (r_scale > SCALE_MAX) begin
            eff_s = SCALE_MAX;
        end else begin
            eff_s = r_scale;
        end
        if (r_src_width == '0) begin
            eff_w = WW'(1);
        end else if (32'(r_src_width) > MAX_WIDTH) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(r_src_width);
        end
        if (r_src_height == '0) begin
            eff_h = HEIGHT_W'(1);
        end else if (r_src_height > HEIGHT_MAX) begin
            eff_h = HEIGHT_MAX;
        end else begin
            eff_h = r_src_height;
        end
    end

    assign data_len = ROW_W'(eff_w) + ROW_W'({eff_w, 1'b0});
    assign row_len  = data_len + ROW_W'(2'(2'd0 - data_len[1:0]));
    // only the low two bits of the scaled row length set the output padding
    assign pad_out  = 2'(2'd0 - 2'(data_len[1:0] * eff_s[1:0]));

    assign b_move          = r_b_vld && (!r_o_vld || i_m_axis_tready);
    assign s_ready         = !r_b_vld || b_move;
    assign o_s_axis_tready = s_ready;
    assign accept          = i_s_axis_tvalid && s_ready;
    assign byte_go         = accept && (i_s_axis_tuser == KIND_DATA) && !r_row_ready;
    assign tick_go         = accept && (i_s_axis_tuser == KIND_TICK) && r_row_ready;

    assign in_data = r_pix_pos < eff_w;
    assign wr_en   = byte_go && (r_in_pos < data_len);
    assign rd_en   = tick_go && in_data;
    assign wr_addr = AW'(r_in_pos);
    assign rd_addr = AW'(ROW_W'(r_pix_pos) + ROW_W'({r_pix_pos, 1'b0}) + ROW_W'(r_bip));

    always_comb begin
        logic [SCALE_W:0]    rep_inc;
        logic [SCALE_W:0]    copy_inc;
        logic [2:0]          pad_inc;
        logic [WW:0]         pos_inc;
        logic [ROWCNT_W:0]   row_inc;
        logic [ROW_W:0]      in_inc;

        n_in_pos    = r_in_pos;
        n_row_ready = r_row_ready;
        n_pix_pos   = r_pix_pos;
        n_bip       = r_bip;
        n_rep       = r_rep;
        n_copy      = r_copy;
        n_pad       = r_pad;
        n_src_row   = r_src_row;
        row_end     = 1'b0;
        img_end     = 1'b0;

        rep_inc  = {1'b0, r_rep} + 1'b1;
        copy_inc = {1'b0, r_copy} + 1'b1;
        pad_inc  = {1'b0, r_pad} + 1'b1;
        pos_inc  = {1'b0, r_pix_pos} + 1'b1;
        row_inc  = {1'b0, r_src_row} + 1'b1;
        in_inc   = {1'b0, r_in_pos} + 1'b1;

        if (byte_go) begin
            if (in_inc >= {1'b0, row_len}) begin
                n_in_pos    = '0;
                n_row_ready = 1'b1;
            end else begin
                n_in_pos = in_inc[ROW_W-1:0];
            end
        end

        if (tick_go) begin
            if (in_data) begin
                if (r_bip >= 2'd2) begin
                    n_bip = '0;
                    if (rep_inc >= {1'b0, eff_s}) begin
                        n_rep     = '0;
                        n_pix_pos = pos_inc[WW-1:0];
                        if (pos_inc >= {1'b0, eff_w} && pad_out == 2'd0) begin
                            row_end = 1'b1;
                        end
                    end else begin
                        n_rep = rep_inc[SCALE_W-1:0];
                    end
                end else begin
                    n_bip = r_bip + 2'd1;
                end
            end else begin
                n_pad = pad_inc[1:0];
                if (pad_inc >= {1'b0, pad_out}) begin
                    row_end = 1'b1;
                end
            end

            if (row_end) begin
                n_pix_pos = '0;
                n_bip     = '0;
                n_rep     = '0;
                n_pad     = '0;
                if (copy_inc >= {1'b0, eff_s}) begin
                    n_copy      = '0;
                    n_row_ready = 1'b0;
                    if (row_inc >= {1'b0, eff_h}) begin
                        n_src_row = '0;
                        img_end   = 1'b1;
                    end else begin
                        n_src_row = row_inc[ROWCNT_W-1:0];
                    end
                end else begin
                    n_copy = copy_inc[SCALE_W-1:0];
                end
            end
        end
    end

    // line store: one write port for the filling row, one read port for the draining row
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_line_store[wr_addr] <= i_s_axis_tdata;
        end
        if (rd_en) begin
            r_q <= r_line_store[rd_addr];
        end
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale      <= SCALE_W'(1);
            r_src_width  <= SWIDTH_W'(1);
            r_src_height <= HEIGHT_W'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SCALE:  r_scale      <= i_cfg_data[SCALE_W-1:0];
                CFG_WIDTH:  r_src_width  <= i_cfg_data[SWIDTH_W-1:0];
                CFG_HEIGHT: r_src_height <= i_cfg_data[HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_pos    <= '0;
            r_row_ready <= 1'b0;
            r_pix_pos   <= '0;
            r_bip       <= '0;
            r_rep       <= '0;
            r_copy      <= '0;
            r_pad       <= '0;
            r_src_row   <= '0;
        end else begin
            r_in_pos    <= n_in_pos;
            r_row_ready <= n_row_ready;
            r_pix_pos   <= n_pix_pos;
            r_bip       <= n_bip;
            r_rep       <= n_rep;
            r_copy      <= n_copy;
            r_pad       <= n_pad;
            r_src_row   <= n_src_row;
        end
    end

    // read stage: flags travel alongside the memory read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (s_ready) begin
            r_b_vld <= tick_go;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick_go) begin
            r_b_pad  <= !in_data;
            r_b_last <= row_end;
            r_b_img  <= img_end;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (b_move) begin
            r_o_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_move) begin
            r_o_data <= r_b_pad ? PAD_BYTE : r_q;
            r_o_last <= r_b_last;
            r_o_img  <= r_b_img;
        end
    end

    assign o_m_axis_tvalid = r_o_vld;
    assign o_m_axis_tdata  = r_o_data;
    assign o_m_axis_tlast  = r_o_last;
    assign o_m_axis_tuser  = r_o_img;

`ifndef NO_ASSERTIONS
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(wr_en && rd_en))
        else $error("line store written and read in one cycle");

    a_img_on_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tlast)
        else $error("image end without row end");

    a_read_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_vld && r_o_vld && !i_m_axis_tready |=> r_b_vld && $stable(r_q))
        else $error("read stage lost data under stall");

    a_row_flag_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_row_ready && !r_b_vld && !r_o_vld)
        else $error("control state not cleared by reset");
`endif

endmodule
